// ----- rtl/mqtt_packet_framer_core_macros.svh -----
// Assertion helpers for the MQTT framer
`ifndef MQTT_PACKET_FRAMER_CORE_MACROS_SVH
`define MQTT_PACKET_FRAMER_CORE_MACROS_SVH

`ifndef SYNTH
`define MPF_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("mpf check failed");
`define MPF_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("mpf check failed");
`else
`define MPF_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons)
`define MPF_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)
`endif

`endif

// ----- rtl/mpf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mpf_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  localparam logic [7:0] TYPE_CONNECT   = 8'h10;
  localparam int         LEN_ACC_W      = 28;
  localparam int         LEN_TOTAL_W    = LEN_ACC_W + 1;
  localparam logic [2:0] LEN_MAX_BYTES  = 3'd4;

  // bit offset of each 7-bit length group, least significant group first
  function automatic logic [4:0] group_shift(input logic [1:0] idx);
    logic [4:0] sh;
    begin
      case (idx)
        2'd0:    sh = 5'd0;
        2'd1:    sh = 5'd7;
        2'd2:    sh = 5'd14;
        default: sh = 5'd21;
      endcase
      return sh;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mqtt_packet_framer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A byte accepted appears on the output in the next cycle. Throughput: one
// byte per cycle unless stalled; the single output register is the only stage,
// and it takes a new byte in the same cycle its current one is taken.
// Reset (rst, synchronous, active high) clears the framing state and the output
// valid, so the next byte taken is treated as a packet type byte.

`include "mqtt_packet_framer_core_macros.svh"

module mqtt_packet_framer_core #(
  parameter int BUFFER_BYTES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            packet_end,
  output logic            connect_packet,
  output logic [1:0]      status
);

  // position reaches BUFFER_BYTES, and count one more than that
  localparam int POS_W = $clog2(BUFFER_BYTES + 2);
  localparam logic [POS_W-1:0] POS_LIM = POS_W'(BUFFER_BYTES);
  localparam logic [mpf_pkg::LEN_TOTAL_W-1:0] TOTAL_LIM =
    mpf_pkg::LEN_TOTAL_W'(BUFFER_BYTES);

  logic [POS_W-1:0]              byte_position, byte_position_next;
  logic [2:0]                    length_bytes_seen, length_bytes_seen_next;
  logic                          header_complete, header_complete_next;
  logic [mpf_pkg::LEN_ACC_W-1:0] length_accumulator, length_accumulator_next;
  logic                          connect_seen, connect_seen_next;
  logic [POS_W-1:0]              packet_total, packet_total_next;

  logic                          in_accept;
  logic [POS_W-1:0]              count;
  logic [2:0]                    lbs_inc;
  logic [mpf_pkg::LEN_ACC_W-1:0] acc_sum;
  logic [mpf_pkg::LEN_TOTAL_W-1:0] total;
  logic [mpf_pkg::LEN_TOTAL_W-1:0] count_wide;
  mpf_pkg::status_t              st_next;
  logic                          end_next;
  logic                          frame_close;
  logic                          hdr_len_ok;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign count      = byte_position + 1'b1;
  assign count_wide = mpf_pkg::LEN_TOTAL_W'(count);
  assign lbs_inc    = length_bytes_seen + 3'd1;
  assign acc_sum    = length_accumulator
                    + (mpf_pkg::LEN_ACC_W'(data_byte[6:0])
                       << mpf_pkg::group_shift(length_bytes_seen[1:0]));
  assign total      = mpf_pkg::LEN_TOTAL_W'(1)
                    + mpf_pkg::LEN_TOTAL_W'(lbs_inc)
                    + mpf_pkg::LEN_TOTAL_W'(acc_sum);

  always_comb begin
    byte_position_next      = byte_position;
    length_bytes_seen_next  = length_bytes_seen;
    header_complete_next    = header_complete;
    length_accumulator_next = length_accumulator;
    connect_seen_next       = connect_seen;
    packet_total_next       = packet_total;
    st_next                 = mpf_pkg::ST_OK;
    end_next                = 1'b0;

    if (byte_position == '0) begin
      connect_seen_next = (data_byte == mpf_pkg::TYPE_CONNECT);
      if (count > POS_LIM) begin
        st_next = mpf_pkg::ST_OVERFLOW;
      end else begin
        byte_position_next = count;
      end
    end else if (!header_complete) begin
      if (data_byte[7] && (lbs_inc >= mpf_pkg::LEN_MAX_BYTES)) begin
        st_next = mpf_pkg::ST_MALFORMED;
      end else if (count > POS_LIM) begin
        st_next = mpf_pkg::ST_OVERFLOW;
      end else begin
        byte_position_next      = count;
        length_accumulator_next = acc_sum;
        length_bytes_seen_next  = lbs_inc;
        if (!data_byte[7]) begin
          header_complete_next = 1'b1;
          // total fits the position width whenever it is not an overflow
          packet_total_next    = total[POS_W-1:0];
          if (total > TOTAL_LIM) begin
            st_next = mpf_pkg::ST_OVERFLOW;
          end else if (count_wide >= total) begin
            end_next = 1'b1;
          end
        end
      end
    end else begin
      if (count > POS_LIM) begin
        st_next = mpf_pkg::ST_OVERFLOW;
      end else begin
        byte_position_next = count;
        if (count >= packet_total) begin
          end_next = 1'b1;
        end
      end
    end

    // frame done or dropped: next byte opens a new packet
    if (st_next != mpf_pkg::ST_OK || end_next) begin
      byte_position_next      = '0;
      length_bytes_seen_next  = '0;
      header_complete_next    = 1'b0;
      length_accumulator_next = '0;
      connect_seen_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      length_bytes_seen  <= '0;
      header_complete    <= 1'b0;
      length_accumulator <= '0;
      connect_seen       <= 1'b0;
      packet_total       <= '0;
    end else if (in_accept) begin
      byte_position      <= byte_position_next;
      length_bytes_seen  <= length_bytes_seen_next;
      header_complete    <= header_complete_next;
      length_accumulator <= length_accumulator_next;
      connect_seen       <= connect_seen_next;
      packet_total       <= packet_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_byte       <= data_byte;
      packet_end     <= end_next;
      connect_packet <= (byte_position == '0) ? (data_byte == mpf_pkg::TYPE_CONNECT)
                                              : connect_seen;
      status         <= st_next;
    end
  end

  assign frame_close = in_accept && (end_next || st_next != mpf_pkg::ST_OK);
  assign hdr_len_ok  = (length_bytes_seen != 3'd0)
                     && (length_bytes_seen <= mpf_pkg::LEN_MAX_BYTES);

  `MPF_ASSERT_SAME(a_end_only_ok, clk, rst, out_valid && packet_end, status == mpf_pkg::ST_OK)
  `MPF_ASSERT_NEXT(a_clear_after_frame, clk, rst, frame_close, byte_position == '0)
  `MPF_ASSERT_SAME(a_pos_in_range, clk, rst, 1'b1, byte_position <= POS_LIM)
  `MPF_ASSERT_SAME(a_hdr_len_bytes, clk, rst, header_complete, hdr_len_ok)

endmodule

`default_nettype wire
